[sv/delta_timer_event_queue_top_defines.svh]
// Assertion macros used by the delta timer event queue top level.
`ifndef DELTA_TIMER_EVENT_QUEUE_TOP_DEFINES_SVH
`define DELTA_TIMER_EVENT_QUEUE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DTEQ_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DTEQ_ASSERT_RST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTEQ_ASSERT(name, clk, rst, prop, msg)
`define DTEQ_ASSERT_RST(name, clk, prop, msg)
`endif
`endif

[sv/dteq_pkg.sv]
// Types and codes of the delta timer event queue.
package dteq_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_POP    = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  localparam int CountOutWidth = 7;

  typedef struct packed {
    logic [31:0] delta;
    logic [15:0] pid;
    logic [1:0]  kind;
    logic [7:0]  factor;
  } entry_t;

  typedef struct packed {
    logic   shift;
    logic   wr_en;
    entry_t wr_data;
  } chain_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_POP,
    ST_REM,
    ST_FIN
  } state_t;

endpackage

[sv/dteq_if.sv]
// Input and result channel interfaces of the delta timer event queue.
interface dteq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] event_time;
  logic [15:0] pid;
  logic [1:0]  event_kind;
  logic [7:0]  factor;

  modport source (output valid, mode, event_time, pid, event_kind, factor, input ready);
  modport sink (input valid, mode, event_time, pid, event_kind, factor, output ready);
endinterface

interface dteq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] out_delta;
  logic [15:0] out_pid;
  logic [1:0]  out_kind;
  logic [7:0]  out_factor;
  logic [6:0]  removed_count;
  logic [6:0]  queue_size;

  modport source (output valid, status, out_delta, out_pid, out_kind, out_factor,
                  removed_count, queue_size, input ready);
  modport sink (input valid, status, out_delta, out_pid, out_kind, out_factor,
                removed_count, queue_size, output ready);
endinterface

[sv/dteq_cell.sv]
// One cell of the entry chain: holds one entry and loads from its neighbour or the write port.
module dteq_cell #(
  parameter int IW  = 6,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  dteq_pkg::chain_cmd_t cmd,
  input  logic [IW-1:0]       wr_pos,
  input  dteq_pkg::entry_t    nbr,
  output dteq_pkg::entry_t    q
);
  import dteq_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.wr_en && (wr_pos == IW'(IDX))) begin
      q <= cmd.wr_data;
    end else if (cmd.shift) begin
      q <= nbr;
    end
  end

endmodule

[sv/dteq_ctrl.sv]
// Sequencer of the delta timer event queue: walks the chain and holds the result register.
module dteq_ctrl #(
  parameter int DEPTH = 64,
  parameter int CW    = 7,
  parameter int IW    = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  dteq_in_if.sink              in_ch,
  dteq_out_if.source           out_ch,
  input  dteq_pkg::entry_t     head,
  output dteq_pkg::chain_cmd_t cmd,
  output logic [IW-1:0]        wr_pos,
  output logic [CW-1:0]        count
);
  import dteq_pkg::*;

  state_t        state, state_next;
  logic [CW-1:0] count_next;
  logic [CW-1:0] left, left_next;
  logic [CW-1:0] removed, removed_next;
  logic [31:0]   t, t_next;
  logic [31:0]   carry, carry_next;
  logic          found, found_next;
  logic [15:0]   key_pid, key_pid_next;
  entry_t        nent, nent_next;
  entry_t        res_pop, res_pop_next;
  status_t       res_status, res_status_next;
  logic          out_valid, out_valid_next;
  status_t       out_status, out_status_next;
  entry_t        out_ent, out_ent_next;
  logic [6:0]    out_removed, out_removed_next;
  logic [6:0]    out_size, out_size_next;
  logic [CW-1:0] wpos;
  logic [31:0]   sum;
  logic          accept;
  logic          out_free;

  assign in_ch.ready          = (state == ST_IDLE) && !rst;
  assign accept               = in_ch.valid && in_ch.ready;
  assign out_free             = !out_valid || out_ch.ready;
  assign wr_pos               = wpos[IW-1:0];
  assign sum                  = head.delta + carry;
  assign out_ch.valid         = out_valid;
  assign out_ch.status        = out_status;
  assign out_ch.out_delta     = out_ent.delta;
  assign out_ch.out_pid       = out_ent.pid;
  assign out_ch.out_kind      = out_ent.kind;
  assign out_ch.out_factor    = out_ent.factor;
  assign out_ch.removed_count = out_removed;
  assign out_ch.queue_size    = out_size;

  always_comb begin
    state_next       = state;
    count_next       = count;
    left_next        = left;
    removed_next     = removed;
    t_next           = t;
    carry_next       = carry;
    found_next       = found;
    key_pid_next     = key_pid;
    nent_next        = nent;
    res_pop_next     = res_pop;
    res_status_next  = res_status;
    out_valid_next   = out_valid && !out_ch.ready;
    out_status_next  = out_status;
    out_ent_next     = out_ent;
    out_removed_next = out_removed;
    out_size_next    = out_size;
    cmd              = '0;
    wpos             = count - 1'b1;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          key_pid_next    = in_ch.pid;
          t_next          = in_ch.event_time;
          nent_next       = '{delta: in_ch.event_time, pid: in_ch.pid,
                              kind: in_ch.event_kind, factor: in_ch.factor};
          found_next      = 1'b0;
          left_next       = count;
          carry_next      = '0;
          removed_next    = '0;
          res_status_next = STAT_OK;
          res_pop_next    = '0;
          state_next      = ST_FIN;
          case (in_ch.mode)
            MODE_INSERT: begin
              if (count >= CW'(DEPTH)) begin
                res_status_next = STAT_FULL;
              end else begin
                state_next = ST_INS;
              end
            end
            MODE_POP: begin
              if (count == '0) begin
                res_status_next = STAT_EMPTY;
              end else begin
                state_next = ST_POP;
              end
            end
            MODE_REMOVE: begin
              if (count == '0) begin
                res_status_next = STAT_EMPTY;
              end else begin
                state_next = ST_REM;
              end
            end
            default: begin
              state_next = ST_FIN;
            end
          endcase
        end
      end
      ST_INS: begin
        if (left == '0) begin
          if (!found) begin
            wpos               = count;
            cmd.wr_en          = 1'b1;
            cmd.wr_data        = nent;
            cmd.wr_data.delta  = t;
            count_next         = count + 1'b1;
          end
          state_next = ST_FIN;
        end else if (!found && (head.delta <= t)) begin
          t_next      = t - head.delta;
          cmd.shift   = 1'b1;
          cmd.wr_en   = 1'b1;
          cmd.wr_data = head;
          left_next   = left - 1'b1;
        end else if (!found) begin
          wpos              = count;
          cmd.wr_en         = 1'b1;
          cmd.wr_data       = nent;
          cmd.wr_data.delta = t;
          count_next        = count + 1'b1;
          found_next        = 1'b1;
        end else begin
          cmd.shift         = 1'b1;
          cmd.wr_en         = 1'b1;
          cmd.wr_data       = head;
          cmd.wr_data.delta = head.delta - t;
          t_next            = '0;
          left_next         = left - 1'b1;
        end
      end
      ST_POP: begin
        res_pop_next = head;
        cmd.shift    = 1'b1;
        count_next   = count - 1'b1;
        state_next   = ST_FIN;
      end
      ST_REM: begin
        if (left == '0) begin
          state_next = ST_FIN;
        end else begin
          cmd.shift = 1'b1;
          left_next = left - 1'b1;
          if (head.pid == key_pid) begin
            count_next   = count - 1'b1;
            carry_next   = sum;
            removed_next = removed + 1'b1;
          end else begin
            cmd.wr_en         = 1'b1;
            cmd.wr_data       = head;
            cmd.wr_data.delta = sum;
            carry_next        = '0;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          out_status_next  = res_status;
          out_ent_next     = res_pop;
          out_removed_next = CountOutWidth'(removed);
          out_size_next    = CountOutWidth'(count);
          state_next       = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    left        <= left_next;
    removed     <= removed_next;
    t           <= t_next;
    carry       <= carry_next;
    found       <= found_next;
    key_pid     <= key_pid_next;
    nent        <= nent_next;
    res_pop     <= res_pop_next;
    res_status  <= res_status_next;
    out_status  <= out_status_next;
    out_ent     <= out_ent_next;
    out_removed <= out_removed_next;
    out_size    <= out_size_next;
  end

endmodule

[sv/delta_timer_event_queue_top.sv]
// Top level of the delta timer event queue: a chain of entry cells and its sequencer.
//
//   channel  role    handshake      payload
//   in_ch    sink    valid / ready  mode, event_time, pid, event_kind, factor
//   out_ch   source  valid / ready  status, out_delta, out_pid, out_kind, out_factor,
//                                   removed_count, queue_size
//
// Insert and remove rotate the whole chain through its head, one entry a cycle, except in the
// step in which insert writes the new entry, which happens when it goes in front of an existing
// one or at the tail. Pop takes the head and shifts the chain once; a rejected, empty or unused
// operation goes straight to its result. The input is not ready while reset is high.
// Reset clears the entry count, the control state and the output valid flag only; the cells are never cleared.
// A new item is taken while a result still waits in the output register; the sequencer
// then holds its finished result until that register is free.
module delta_timer_event_queue_top #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  dteq_in_if.sink    in_ch,
  dteq_out_if.source out_ch
);
  import dteq_pkg::*;

  `include "delta_timer_event_queue_top_defines.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  chain_cmd_t    cmd;
  logic [IW-1:0] wr_pos;
  logic [CW-1:0] count;
  entry_t        cell_q [DEPTH];
  logic          in_take;

  assign in_take = in_ch.valid && in_ch.ready;

  dteq_ctrl #(
    .DEPTH (DEPTH),
    .CW    (CW),
    .IW    (IW)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .head   (cell_q[0]),
    .cmd    (cmd),
    .wr_pos (wr_pos),
    .count  (count)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == DEPTH - 1) begin : g_last
      dteq_cell #(
        .IW  (IW),
        .IDX (i)
      ) u_cell (
        .clk    (clk),
        .cmd    (cmd),
        .wr_pos (wr_pos),
        .nbr    (cell_q[i]),
        .q      (cell_q[i])
      );
    end else begin : g_mid
      dteq_cell #(
        .IW  (IW),
        .IDX (i)
      ) u_cell (
        .clk    (clk),
        .cmd    (cmd),
        .wr_pos (wr_pos),
        .nbr    (cell_q[i+1]),
        .q      (cell_q[i])
      );
    end
  end

  `DTEQ_ASSERT(a_count_range, clk, rst, count <= CW'(DEPTH), "entry count beyond depth")
  `DTEQ_ASSERT(a_busy_after_accept, clk, rst, in_take |=> !in_ch.ready, "item taken while busy")
  `DTEQ_ASSERT_RST(a_reset_empty, clk, rst |=> count == '0 && !out_ch.valid, "not empty after reset")

endmodule
